>>> sv/imuse_pkg.sv
// Shared constants and types of the IMU sample scaler with accelerometer smoothing.
package imuse_pkg;

  localparam int RawW    = 16;
  localparam int TempW   = 18;
  localparam int AccW    = 21;
  localparam int GyrW    = 20;
  localparam int AlphaW  = 16;
  localparam int KW      = 21;
  localparam int ScaledW = 21;
  localparam int ProdW   = 37;
  localparam int EmaProdW = 39;

  localparam logic [KW-1:0] TempK = 21'd126640;
  localparam logic [KW-1:0] AccK  = 21'd1285377;
  localparam logic [KW-1:0] GyrK  = 21'd1023001;

  localparam logic signed [TempW-1:0] TempOfs    = 18'sd6400;
  localparam logic [AlphaW-1:0]       AlphaReset = 16'd13107;

  typedef struct packed {
    logic capture;
    logic round;
    logic ema_mul;
    logic update;
    logic seed;
  } lane_ctrl_t;

endpackage

>>> sv/imuse_ifs.sv
// Handshake interfaces for the sample, result and configuration channels.
interface imuse_in_if;
  import imuse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RawW-1:0]   raw_temp;
  logic signed [RawW-1:0]   raw_accel_x;
  logic signed [RawW-1:0]   raw_accel_y;
  logic signed [RawW-1:0]   raw_accel_z;
  logic signed [RawW-1:0]   raw_gyro_x;
  logic signed [RawW-1:0]   raw_gyro_y;
  logic signed [RawW-1:0]   raw_gyro_z;
  modport source (output valid, raw_temp, raw_accel_x, raw_accel_y, raw_accel_z,
                  raw_gyro_x, raw_gyro_y, raw_gyro_z, input ready);
  modport sink (input valid, raw_temp, raw_accel_x, raw_accel_y, raw_accel_z,
                raw_gyro_x, raw_gyro_y, raw_gyro_z, output ready);
endinterface

interface imuse_out_if;
  import imuse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TempW-1:0]  temp_c;
  logic signed [AccW-1:0]   accel_x_smooth;
  logic signed [AccW-1:0]   accel_y_smooth;
  logic signed [AccW-1:0]   accel_z_smooth;
  logic signed [GyrW-1:0]   rate_x;
  logic signed [GyrW-1:0]   rate_y;
  logic signed [GyrW-1:0]   rate_z;
  modport source (output valid, temp_c, accel_x_smooth, accel_y_smooth, accel_z_smooth,
                  rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, temp_c, accel_x_smooth, accel_y_smooth, accel_z_smooth,
                rate_x, rate_y, rate_z, output ready);
endinterface

interface imuse_cfg_if;
  import imuse_pkg::*;
  logic              valid;
  logic              ready;
  logic [AlphaW-1:0] smooth_weight;
  modport source (output valid, smooth_weight, input ready);
  modport sink (input valid, smooth_weight, output ready);
endinterface

>>> sv/imu_sample_scale_ema_unit.sv
// Top level of the IMU sample scaler with accelerometer moving-average filter.
//
// A sample set is taken on in_i with a transfer when valid and ready are high.
// Seven scaling lanes multiply the raw words by their Q16 constants, three
// smoothing lanes filter the acceleration, and a merge stage adds the
// temperature offset and loads the output register driving out_o.
// out_o.valid rises when the update loads the output register: the transfer edge
// captures the products, then rounding, filter product and filter update follow
// in turn. A new sample is taken only after the last one is done, since the
// input is ready again only once the update has loaded the output register.
// While a finished result waits on out_o, the next sample is still taken and
// worked on up to its update step, which then waits for the output register.
// cfg_i writes the smoothing weight; cfg_i.ready is always high.
// Reset sets the weight to 13107, clears the filter and marks it unseeded, so
// the first sample after reset loads the filter directly. No result is lost
// or repeated when the receiver stalls.
module imu_sample_scale_ema_unit (
  input logic          clk_i,
  input logic          rst_ni,
  imuse_in_if.sink     in_i,
  imuse_out_if.source  out_o,
  imuse_cfg_if.sink    cfg_i
);
  import imuse_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_EMA,
    S_UPDATE
  } state_e;

  state_e            state_q;
  state_e            state_d;
  lane_ctrl_t        ctrl;
  logic              seeded_q;
  logic [AlphaW-1:0] alpha_q;
  logic              out_valid_q;
  logic              in_ready;
  logic              load_out;

  logic signed [ScaledW-1:0] s_temp, s_ax, s_ay, s_az, s_gx, s_gy, s_gz;
  logic signed [AccW-1:0]    n_ax, n_ay, n_az;

  logic signed [TempW-1:0] temp_q;
  logic signed [AccW-1:0]  ax_q, ay_q, az_q;
  logic signed [GyrW-1:0]  gx_q, gy_q, gz_q;

  assign in_ready    = (state_q == S_IDLE);
  assign load_out    = (state_q == S_UPDATE) && (!out_valid_q || out_o.ready);
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  assign ctrl.capture = in_i.valid && in_ready;
  assign ctrl.round   = (state_q == S_ROUND);
  assign ctrl.ema_mul = (state_q == S_EMA);
  assign ctrl.update  = load_out;
  assign ctrl.seed    = !seeded_q;

  imuse_scale_lane u_lane_t  (.clk_i, .ctrl_i(ctrl), .raw_i(in_i.raw_temp),
                              .k_i(TempK), .scaled_o(s_temp));
  imuse_scale_lane u_lane_ax (.clk_i, .ctrl_i(ctrl), .raw_i(in_i.raw_accel_x),
                              .k_i(AccK), .scaled_o(s_ax));
  imuse_scale_lane u_lane_ay (.clk_i, .ctrl_i(ctrl), .raw_i(in_i.raw_accel_y),
                              .k_i(AccK), .scaled_o(s_ay));
  imuse_scale_lane u_lane_az (.clk_i, .ctrl_i(ctrl), .raw_i(in_i.raw_accel_z),
                              .k_i(AccK), .scaled_o(s_az));
  imuse_scale_lane u_lane_gx (.clk_i, .ctrl_i(ctrl), .raw_i(in_i.raw_gyro_x),
                              .k_i(GyrK), .scaled_o(s_gx));
  imuse_scale_lane u_lane_gy (.clk_i, .ctrl_i(ctrl), .raw_i(in_i.raw_gyro_y),
                              .k_i(GyrK), .scaled_o(s_gy));
  imuse_scale_lane u_lane_gz (.clk_i, .ctrl_i(ctrl), .raw_i(in_i.raw_gyro_z),
                              .k_i(GyrK), .scaled_o(s_gz));

  imuse_ema_lane u_ema_x (.clk_i, .rst_ni, .ctrl_i(ctrl), .x_i(s_ax),
                          .alpha_i(alpha_q), .smooth_next_o(n_ax));
  imuse_ema_lane u_ema_y (.clk_i, .rst_ni, .ctrl_i(ctrl), .x_i(s_ay),
                          .alpha_i(alpha_q), .smooth_next_o(n_ay));
  imuse_ema_lane u_ema_z (.clk_i, .rst_ni, .ctrl_i(ctrl), .x_i(s_az),
                          .alpha_i(alpha_q), .smooth_next_o(n_az));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (ctrl.capture) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND:  state_d = S_EMA;
      S_EMA:    state_d = S_UPDATE;
      S_UPDATE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      alpha_q     <= AlphaReset;
      out_valid_q <= 1'b0;
      temp_q      <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      az_q        <= '0;
      gx_q        <= '0;
      gy_q        <= '0;
      gz_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        alpha_q <= cfg_i.smooth_weight;
      end
      if (load_out) begin
        seeded_q    <= 1'b1;
        out_valid_q <= 1'b1;
        temp_q      <= s_temp[TempW-1:0] + TempOfs;
        ax_q        <= n_ax;
        ay_q        <= n_ay;
        az_q        <= n_az;
        gx_q        <= s_gx[GyrW-1:0];
        gy_q        <= s_gy[GyrW-1:0];
        gz_q        <= s_gz[GyrW-1:0];
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.temp_c         = temp_q;
  assign out_o.accel_x_smooth = ax_q;
  assign out_o.accel_y_smooth = ay_q;
  assign out_o.accel_z_smooth = az_q;
  assign out_o.rate_x         = gx_q;
  assign out_o.rate_y         = gy_q;
  assign out_o.rate_z         = gz_q;

endmodule

>>> sv/imuse_scale_lane.sv
// One scaling lane: raw word times a Q16 constant, rounded to nearest.
module imuse_scale_lane (
  input  logic                                    clk_i,
  input  imuse_pkg::lane_ctrl_t                   ctrl_i,
  input  logic signed [imuse_pkg::RawW-1:0]       raw_i,
  input  logic [imuse_pkg::KW-1:0]                k_i,
  output logic signed [imuse_pkg::ScaledW-1:0]    scaled_o
);
  import imuse_pkg::*;

  logic signed [KW:0]        k_s;
  logic signed [ProdW:0]     prod_full;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [ProdW:0]     biased;
  logic signed [ScaledW-1:0] scaled_q;

  assign k_s       = $signed({1'b0, k_i});
  assign prod_full = raw_i * k_s;
  assign biased    = {prod_q[ProdW-1], prod_q} + (ProdW+1)'(32768);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      prod_q <= prod_full[ProdW-1:0];
    end
    if (ctrl_i.round) begin
      scaled_q <= biased[ScaledW+15:16];
    end
  end

  assign scaled_o = scaled_q;

endmodule

>>> sv/imuse_ema_lane.sv
// One smoothing lane: first-order moving average with seeding on the first sample.
module imuse_ema_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  imuse_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [imuse_pkg::AccW-1:0]     x_i,
  input  logic [imuse_pkg::AlphaW-1:0]          alpha_i,
  output logic signed [imuse_pkg::AccW-1:0]     smooth_next_o
);
  import imuse_pkg::*;

  logic signed [AccW-1:0]     f_q;
  logic signed [AccW-1:0]     f_d;
  logic signed [AccW:0]       diff;
  logic signed [AlphaW:0]     alpha_s;
  logic signed [EmaProdW-1:0] prod_full;
  logic signed [EmaProdW-1:0] prod_q;
  logic signed [EmaProdW:0]   biased;
  logic signed [AccW:0]       sum;

  assign diff      = {x_i[AccW-1], x_i} - {f_q[AccW-1], f_q};
  assign alpha_s   = $signed({1'b0, alpha_i});
  assign prod_full = alpha_s * diff;
  assign biased    = {prod_q[EmaProdW-1], prod_q} + (EmaProdW+1)'(32768);
  assign sum       = {f_q[AccW-1], f_q} + biased[AccW+16:16];
  assign f_d       = ctrl_i.seed ? x_i : sum[AccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
    end else if (ctrl_i.update) begin
      f_q <= f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ema_mul) begin
      prod_q <= prod_full;
    end
  end

  assign smooth_next_o = f_d;

endmodule
